// ----- sv/shared_buffer_multi_queue_top_assert.svh -----
// Assertion macros used by the queue store controller.
`ifndef SHARED_BUFFER_MULTI_QUEUE_TOP_ASSERT_SVH
`define SHARED_BUFFER_MULTI_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SBMQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("queue store assertion failed");

// Next-cycle implication, checked out of reset.
`define SBMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("queue store assertion failed");

`endif

// ----- sv/sbmq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sbmq_pkg;

    localparam int NUM_QUEUES = 8;
    localparam int NUM_SLOTS  = 64;
    localparam int DATA_W     = 32;
    localparam int QNUM_W     = 3;
    localparam int STATUS_W   = 2;

    // Slot indexes carry one more code than there are slots: the null link.
    localparam int SIDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int LINK_W = $clog2(NUM_SLOTS + 1);
    localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

    typedef logic [LINK_W-1:0] link_t;

    localparam link_t LINK_NULL = link_t'(NUM_SLOTS);

    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    typedef enum logic {
        CS_IDLE,
        CS_EXEC
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic update;
    } dp_cmd_t;

endpackage

`default_nettype wire

// ----- sv/sbmq_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface sbmq_req_if;
    import sbmq_pkg::*;

    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [QNUM_W-1:0]           queue_number;
    logic signed [DATA_W-1:0]    value;

    modport source (output valid, output action, output queue_number, output value,
                    input ready);
    modport sink   (input valid, input action, input queue_number, input value,
                    output ready);
endinterface

`default_nettype wire

// ----- sv/sbmq_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface sbmq_rsp_if;
    import sbmq_pkg::*;

    logic                        valid;
    logic                        ready;
    logic [STATUS_W-1:0]         status;
    logic signed [DATA_W-1:0]    data_out;

    modport source (output valid, output status, output data_out, input ready);
    modport sink   (input valid, input status, input data_out, output ready);
endinterface

`default_nettype wire

// ----- sv/shared_buffer_multi_queue_top.sv -----
// Eight FIFO queues sharing one store of 64 word slots, with unused slots on a linked free list.
// Request channel (req): action (0 enqueue, 1 dequeue), queue_number and value; a request
// is accepted on a rising edge with valid and ready both high.
// Response channel (rsp): one response per request, in request order, carrying status
// (0 done, 1 store full so the enqueue was rejected, 2 queue empty) and data_out, which holds
// the dequeued word on a successful dequeue and zero otherwise.
// Each request is accepted in the idle state, where the accepting edge reads the link and slot
// stores at the queue head or free-list head into registers; in the execute state a later edge
// updates the lists and loads the response register, which also raises the response valid. No
// new request is accepted until that update is done; the link store's single write port and
// its registered read make this so.
// While a response waits in its register, the block still accepts the next request and reads
// for it; its update then holds until the receiver takes the waiting response, so nothing is
// lost or overwritten.
// Reset is asynchronous and active low. It empties every queue and chains all slots on the
// free list at once through per-slot valid bits on the link store, so requests are accepted
// from the first cycle after reset with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module shared_buffer_multi_queue_top (
    input  wire logic  clk,
    input  wire logic  rst_n,
    sbmq_req_if.sink   req,
    sbmq_rsp_if.source rsp
);
    import sbmq_pkg::*;

    dp_cmd_t cmd;
    logic    in_ready;
    logic    out_valid;

    // The controller sequences each request; the datapath owns the stores and lists.
    sbmq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    sbmq_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .action       (req.action),
        .queue_number (req.queue_number),
        .value        (req.value),
        .status       (rsp.status),
        .data_out     (rsp.data_out)
    );

    assign req.ready = in_ready;
    assign rsp.valid = out_valid;

endmodule

`default_nettype wire

// ----- sv/sbmq_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sbmq_dp (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire sbmq_pkg::dp_cmd_t                cmd,
    input  wire logic                             action,
    input  wire logic [sbmq_pkg::QNUM_W-1:0]      queue_number,
    input  wire logic signed [sbmq_pkg::DATA_W-1:0] value,
    output logic [sbmq_pkg::STATUS_W-1:0]         status,
    output logic signed [sbmq_pkg::DATA_W-1:0]   data_out
);
    import sbmq_pkg::*;

    // Slot store and link store; links carry a valid bit so that reset need not sweep.
    logic [DATA_W-1:0]  data_mem [NUM_SLOTS];
    link_t              link_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] link_valid_reg;

    link_t head_reg [NUM_QUEUES];
    link_t tail_reg [NUM_QUEUES];
    link_t free_head_reg;

    // Request held for the update cycle.
    logic               act_reg;
    logic [QNUM_W-1:0]  q_reg;
    logic [DATA_W-1:0]  val_reg;

    link_t              rd_link_reg;
    logic [DATA_W-1:0]  rd_data_reg;

    logic [STATUS_W-1:0] status_reg;
    logic [DATA_W-1:0]   data_out_reg;

    link_t              rd_addr;
    logic [SIDX_W-1:0]  rd_idx;

    logic               q_ok;
    logic [QIDX_W-1:0]  qi;
    link_t              hd;
    link_t              tl;
    logic               hd_null;
    logic               fh_null;
    logic               enq_ok;
    logic               deq_ok;
    logic               link_we;
    link_t              link_waddr;
    link_t              free_head_next;
    link_t              head_next;
    link_t              tail_next;
    logic [STATUS_W-1:0] status_next;

    // Read address: the queue head for a dequeue, the free-list head for an enqueue.
    always_comb
    begin
        if (action == ACT_DEQ)
        begin
            rd_addr = head_reg[queue_number[QIDX_W-1:0]];
        end
        else
        begin
            rd_addr = free_head_reg;
        end
        rd_idx = rd_addr[SIDX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg     <= action;
            q_reg       <= queue_number;
            val_reg     <= value;
            rd_data_reg <= data_mem[rd_idx];
            if (link_valid_reg[rd_idx])
            begin
                rd_link_reg <= link_mem[rd_idx];
            end
            else
            begin
                rd_link_reg <= link_t'(rd_idx) + link_t'(1);
            end
        end
    end

    always_comb
    begin
        q_ok    = (int'(q_reg) < NUM_QUEUES);
        qi      = q_reg[QIDX_W-1:0];
        hd      = head_reg[qi];
        tl      = tail_reg[qi];
        hd_null = (hd == LINK_NULL);
        fh_null = (free_head_reg == LINK_NULL);
        enq_ok  = (act_reg == ACT_ENQ) && q_ok && !fh_null;
        deq_ok  = (act_reg == ACT_DEQ) && q_ok && !hd_null;

        free_head_next = free_head_reg;
        head_next      = hd;
        tail_next      = tl;
        link_we        = 1'b0;
        link_waddr     = hd;

        if (enq_ok)
        begin
            free_head_next = rd_link_reg;
            tail_next      = free_head_reg;
            if (hd_null)
            begin
                head_next = free_head_reg;
            end
            else
            begin
                link_we    = 1'b1;
                link_waddr = tl;
            end
        end
        else if (deq_ok)
        begin
            free_head_next = hd;
            link_we        = 1'b1;
            link_waddr     = hd;
            // The tail's own link is never used: a head equal to the tail drains the queue.
            if (hd == tl)
            begin
                head_next = LINK_NULL;
                tail_next = LINK_NULL;
            end
            else
            begin
                head_next = rd_link_reg;
            end
        end

        if (act_reg == ACT_ENQ)
        begin
            status_next = enq_ok ? STAT_DONE : STAT_FULL;
        end
        else
        begin
            status_next = deq_ok ? STAT_DONE : STAT_EMPTY;
        end
    end

    // Memory writes: the appended or released link, and the enqueued word.
    always_ff @(posedge clk)
    begin
        if (cmd.update && link_we)
        begin
            if (enq_ok)
            begin
                link_mem[link_waddr[SIDX_W-1:0]] <= free_head_reg;
            end
            else
            begin
                link_mem[link_waddr[SIDX_W-1:0]] <= free_head_reg;
            end
        end
        if (cmd.update && enq_ok)
        begin
            data_mem[free_head_reg[SIDX_W-1:0]] <= val_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_valid_reg <= '0;
            free_head_reg  <= '0;
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                head_reg[i] <= LINK_NULL;
                tail_reg[i] <= LINK_NULL;
            end
        end
        else if (cmd.update)
        begin
            free_head_reg <= free_head_next;
            head_reg[qi]  <= head_next;
            tail_reg[qi]  <= tail_next;
            if (link_we)
            begin
                link_valid_reg[link_waddr[SIDX_W-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            status_reg   <= status_next;
            data_out_reg <= deq_ok ? rd_data_reg : '0;
        end
    end

    assign status   = status_reg;
    assign data_out = data_out_reg;

endmodule

`default_nettype wire

// ----- sv/sbmq_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "shared_buffer_multi_queue_top_assert.svh"

module sbmq_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output sbmq_pkg::dp_cmd_t      cmd
);
    import sbmq_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CS_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            CS_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = CS_EXEC;
                end
            end
            CS_EXEC:
            begin
                // Wait until the result register is free or being emptied.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.update     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    `SBMQ_ASSERT_IMPL(a_update_slot_free, clk, rst_n, cmd.update, !out_valid_reg || out_ready)
    `SBMQ_ASSERT_NEXT(a_accept_to_exec, clk, rst_n, in_valid && in_ready, state_reg == CS_EXEC)
    `SBMQ_ASSERT_NEXT(a_update_gives_result, clk, rst_n, cmd.update, out_valid_reg)
    `SBMQ_ASSERT_IMPL(a_load_only_idle, clk, rst_n, cmd.load, state_reg == CS_IDLE && !cmd.update)

endmodule

`default_nettype wire
